// ===== hdl/cdq_pkg.sv =====
// cdq_pkg: shared types and constants for the circular deque
// depends on nothing; used by cdq_ctrl, cdq_dp and circular_deque
package cdq_pkg;

    localparam int DEPTH  = 16;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int WORD_W = 32;
    localparam int CMD_W  = 3;
    localparam int STAT_W = 2;
    localparam int OCC_W  = 5;

    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH_FRONT = 3'd0,
        CMD_PUSH_BACK  = 3'd1,
        CMD_POP_FRONT  = 3'd2,
        CMD_POP_BACK   = 3'd3,
        CMD_PEEK_FRONT = 3'd4,
        CMD_PEEK_BACK  = 3'd5
    } t_cmd;

    typedef enum logic [STAT_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_RESP
    } t_state;

    typedef struct packed {
        logic latch;
        logic exec;
    } t_dp_ctrl;

    localparam logic [WORD_W-1:0] EMPTY_WORD = '1;

endpackage

// ===== hdl/cdq_ctrl.sv =====
// cdq_ctrl: command sequencer for the circular deque
// depends on cdq_pkg; drives cdq_dp through a t_dp_ctrl struct
module cdq_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    output logic              o_done,
    output cdq_pkg::t_dp_ctrl o_dp_ctrl
);

    cdq_pkg::t_state r_state;
    cdq_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= cdq_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            cdq_pkg::S_IDLE: begin
                if (start) n_state = cdq_pkg::S_EXEC;
            end
            cdq_pkg::S_EXEC: begin
                n_state = cdq_pkg::S_RESP;
            end
            cdq_pkg::S_RESP: begin
                n_state = start ? cdq_pkg::S_EXEC : cdq_pkg::S_IDLE;
            end
            default: begin
                n_state = cdq_pkg::S_IDLE;
            end
        endcase
    end

    always_comb begin
        busy            = 1'b0;
        o_done          = 1'b0;
        o_dp_ctrl.latch = 1'b0;
        o_dp_ctrl.exec  = 1'b0;
        unique case (r_state)
            cdq_pkg::S_IDLE: begin
                o_dp_ctrl.latch = start;
            end
            cdq_pkg::S_EXEC: begin
                busy           = 1'b1;
                o_dp_ctrl.exec = 1'b1;
            end
            cdq_pkg::S_RESP: begin
                o_done          = 1'b1;
                o_dp_ctrl.latch = start;
            end
            default: begin
                busy = 1'b0;
            end
        endcase
    end

endmodule

// ===== hdl/cdq_dp.sv =====
// cdq_dp: deque datapath with the circular store, end pointers and fill count
// depends on cdq_pkg; sequenced by cdq_ctrl
module cdq_dp (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  cdq_pkg::t_dp_ctrl                   i_dp_ctrl,
    input  logic        [cdq_pkg::CMD_W-1:0]    i_command,
    input  logic signed [cdq_pkg::WORD_W-1:0]   i_value,
    output logic signed [cdq_pkg::WORD_W-1:0]   o_data,
    output logic        [cdq_pkg::STAT_W-1:0]   o_status,
    output logic        [cdq_pkg::OCC_W-1:0]    o_occupancy
);

    localparam logic [cdq_pkg::ADDR_W-1:0] LAST_SLOT = cdq_pkg::ADDR_W'(cdq_pkg::DEPTH - 1);
    localparam logic [cdq_pkg::CNT_W-1:0]  FULL_CNT  = cdq_pkg::CNT_W'(cdq_pkg::DEPTH);

    logic [cdq_pkg::WORD_W-1:0] mem [cdq_pkg::DEPTH];

    logic [cdq_pkg::CMD_W-1:0]  r_cmd;
    logic [cdq_pkg::WORD_W-1:0] r_value;
    logic [cdq_pkg::ADDR_W-1:0] r_head, n_head;
    logic [cdq_pkg::ADDR_W-1:0] r_tail, n_tail;
    logic [cdq_pkg::CNT_W-1:0]  r_count, n_count;
    logic [cdq_pkg::WORD_W-1:0] r_res_data, n_res_data;
    logic [cdq_pkg::STAT_W-1:0] r_res_status, n_res_status;
    logic                       r_use_mem, n_use_mem;
    logic [cdq_pkg::WORD_W-1:0] r_rd_data;

    logic                       wr_en;
    logic [cdq_pkg::ADDR_W-1:0] wr_addr;
    logic [cdq_pkg::ADDR_W-1:0] rd_addr;
    logic                       is_empty;
    logic                       is_full;
    logic [cdq_pkg::ADDR_W-1:0] head_dec, head_inc, tail_dec, tail_inc;

    assign is_empty = (r_count == '0);
    assign is_full  = (r_count >= FULL_CNT);
    assign head_dec = (r_head == '0) ? LAST_SLOT : r_head - 1'b1;
    assign head_inc = (r_head == LAST_SLOT) ? '0 : r_head + 1'b1;
    assign tail_dec = (r_tail == '0) ? LAST_SLOT : r_tail - 1'b1;
    assign tail_inc = (r_tail == LAST_SLOT) ? '0 : r_tail + 1'b1;

    always_comb begin
        n_head       = r_head;
        n_tail       = r_tail;
        n_count      = r_count;
        n_res_data   = r_value;
        n_res_status = cdq_pkg::ST_OK;
        n_use_mem    = 1'b0;
        wr_en        = 1'b0;
        wr_addr      = '0;
        rd_addr      = r_head;
        case (r_cmd)
            cdq_pkg::CMD_PUSH_FRONT, cdq_pkg::CMD_PUSH_BACK: begin
                if (is_empty) begin
                    n_head  = '0;
                    n_tail  = '0;
                    n_count = cdq_pkg::CNT_W'(1);
                    wr_en   = 1'b1;
                    wr_addr = '0;
                end else if (is_full) begin
                    n_res_status = cdq_pkg::ST_FULL;
                end else if (r_cmd == cdq_pkg::CMD_PUSH_FRONT) begin
                    n_head  = head_dec;
                    n_count = r_count + 1'b1;
                    wr_en   = 1'b1;
                    wr_addr = head_dec;
                end else begin
                    n_tail  = tail_inc;
                    n_count = r_count + 1'b1;
                    wr_en   = 1'b1;
                    wr_addr = tail_inc;
                end
            end
            cdq_pkg::CMD_POP_FRONT, cdq_pkg::CMD_POP_BACK: begin
                if (is_empty) begin
                    n_res_data   = cdq_pkg::EMPTY_WORD;
                    n_res_status = cdq_pkg::ST_EMPTY;
                end else begin
                    n_use_mem = 1'b1;
                    n_count   = r_count - 1'b1;
                    if (r_cmd == cdq_pkg::CMD_POP_FRONT) begin
                        rd_addr = r_head;
                        n_head  = head_inc;
                    end else begin
                        rd_addr = r_tail;
                        n_tail  = tail_dec;
                    end
                    if (r_count == cdq_pkg::CNT_W'(1)) begin
                        n_head = '0;
                        n_tail = '0;
                    end
                end
            end
            cdq_pkg::CMD_PEEK_FRONT, cdq_pkg::CMD_PEEK_BACK: begin
                if (is_empty) begin
                    n_res_data   = cdq_pkg::EMPTY_WORD;
                    n_res_status = cdq_pkg::ST_EMPTY;
                end else begin
                    n_use_mem = 1'b1;
                    rd_addr   = (r_cmd == cdq_pkg::CMD_PEEK_FRONT) ? r_head : r_tail;
                end
            end
            default: begin
                n_res_data = '0;
            end
        endcase
    end

    // circular store, registered read
    always_ff @(posedge i_clk) begin
        if (i_dp_ctrl.exec && wr_en) begin
            mem[wr_addr] <= r_value;
        end
        if (i_dp_ctrl.exec) begin
            r_rd_data <= mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_dp_ctrl.latch) begin
            r_cmd   <= i_command;
            r_value <= i_value;
        end
        if (i_dp_ctrl.exec) begin
            r_res_data   <= n_res_data;
            r_res_status <= n_res_status;
            r_use_mem    <= n_use_mem;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
        end else if (i_dp_ctrl.exec) begin
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_count <= n_count;
        end
    end

    assign o_data      = r_use_mem ? r_rd_data : r_res_data;
    assign o_status    = r_res_status;
    assign o_occupancy = cdq_pkg::OCC_W'(r_count);

endmodule

// ===== hdl/circular_deque.sv =====
// circular_deque: top level of the double-ended queue
// depends on cdq_pkg, cdq_ctrl and cdq_dp
//
// A command word is taken when start is high and busy is low. It is latched
// into r_cmd and r_value, executed in S_EXEC, and its result word is then on
// o_data, o_status and o_occupancy for exactly one cycle with o_done high in
// S_RESP; there is no way to hold it off, so the receiver must take it then.
// A new command may be issued in the cycle its predecessor's result is shown,
// but none is taken while busy is high. S_EXEC updates the pointers and writes
// the store or reads it through its registered read; S_RESP presents the result.
module circular_deque (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic        [cdq_pkg::CMD_W-1:0]  i_command,
    input  logic signed [cdq_pkg::WORD_W-1:0] i_value,
    output logic                              o_done,
    output logic signed [cdq_pkg::WORD_W-1:0] o_data,
    output logic        [cdq_pkg::STAT_W-1:0] o_status,
    output logic        [cdq_pkg::OCC_W-1:0]  o_occupancy
);

    cdq_pkg::t_dp_ctrl dp_ctrl;

    cdq_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .start     (start),
        .busy      (busy),
        .o_done    (o_done),
        .o_dp_ctrl (dp_ctrl)
    );

    cdq_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_dp_ctrl   (dp_ctrl),
        .i_command   (i_command),
        .i_value     (i_value),
        .o_data      (o_data),
        .o_status    (o_status),
        .o_occupancy (o_occupancy)
    );

endmodule
